/* rtl/ist_pkg.sv */
// Shared types and codes for the reference-counted inode slot table.
// Holds the request/result structs, status codes and default sizes.
// No dependencies; every other file imports this package.
`default_nettype none

package ist_pkg;

  // Default sizes handed to the top-level parameters
  localparam int SLOTS_DEF      = 64;
  localparam int INODE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 16;

  // Request action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_LOAD      = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_SAT       = 3'd3;
  localparam logic [2:0] ST_HELD      = 3'd4;
  localparam logic [2:0] ST_WRITEBACK = 3'd5;
  localparam logic [2:0] ST_IDLE      = 3'd6;

  // One request transfer
  typedef struct packed {
    logic        action;
    logic [15:0] inode_number;
    logic [5:0]  slot;
  } req_t;

  // One result transfer
  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic [15:0] slot_inode;
    logic [15:0] count_after;
  } rsp_t;

  // Flags from the shared compare/count unit to the sequencer
  typedef struct packed {
    logic match;     // stored number equals the key
    logic zero;      // count is zero (slot free)
    logic at_max;    // count is saturated
    logic sum_zero;  // updated count is zero
  } unit_flags_t;

endpackage

`default_nettype wire

/* rtl/refcounted_inode_slot_table.sv */
// Reference-counted inode slot table, top level with the scan sequencer.
// Instantiates ist_store (slot memories) and ist_unit (compare/count unit);
// uses ist_pkg for types and codes.
//
//   channel   handshake               payload
//   request   start, busy (accept on start && !busy)   req  (ist_pkg::req_t)
//   result    done (one-cycle strobe)  rsp  (ist_pkg::rsp_t)
//
// A get scans the slots one per cycle through the single memory read port;
// the result strobe comes after the last slot is checked on a miss or full
// table, earlier on a hit at a low slot, once the matching slot is read.
// A put reads its slot once and then returns its result.
// busy is high from the cycle after acceptance until the result is issued.
// Reset clears all counts at once through per-slot valid flags; no sweep.
// Results cannot be held off: done is high for exactly one cycle.
`default_nettype none

module refcounted_inode_slot_table #(
  parameter int SLOTS      = ist_pkg::SLOTS_DEF,
  parameter int INODE_BITS = ist_pkg::INODE_BITS_DEF,
  parameter int COUNT_BITS = ist_pkg::COUNT_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire ist_pkg::req_t req,
  output logic               done,
  output ist_pkg::rsp_t      rsp
);
  import ist_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PUT  = 2'd2;

  logic [1:0]            state, state_next;
  logic [INODE_BITS-1:0] key, key_next;
  logic [5:0]            slot_q, slot_q_next;
  logic                  oor, oor_next;
  logic [IDX_W-1:0]      rd_idx, rd_idx_next;
  logic [IDX_W-1:0]      free_idx, free_idx_next;
  logic                  free_found, free_found_next;
  rsp_t                  rsp_next;
  logic                  done_next;

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [INODE_BITS-1:0] rd_num;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  num_we, cnt_we;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic [COUNT_BITS-1:0] sum;
  unit_flags_t           flags;
  logic                  req_oor;

  ist_store #(
    .SLOTS      (SLOTS),
    .INODE_BITS (INODE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_num  (rd_num),
    .rd_cnt  (rd_cnt),
    .num_we  (num_we),
    .cnt_we  (cnt_we),
    .wr_addr (wr_addr),
    .wr_num  (key),
    .wr_cnt  (wr_cnt)
  );

  ist_unit #(
    .INODE_BITS (INODE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_unit (
    .number (rd_num),
    .key    (key),
    .count  (rd_cnt),
    .dec    (state == S_PUT),
    .sum    (sum),
    .flags  (flags)
  );

  assign busy    = (state != S_IDLE);
  assign req_oor = (32'(req.slot) >= SLOTS);

  // Sequence the scan and release steps
  always_comb begin
    state_next      = state;
    key_next        = key;
    slot_q_next     = slot_q;
    oor_next        = oor;
    rd_idx_next     = rd_idx;
    free_idx_next   = free_idx;
    free_found_next = free_found;
    rsp_next        = rsp;
    done_next       = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = '0;
    num_we          = 1'b0;
    cnt_we          = 1'b0;
    wr_addr         = rd_idx;
    wr_cnt          = sum;

    case (state)
      S_IDLE: begin
        if (start) begin
          key_next    = INODE_BITS'(req.inode_number);
          slot_q_next = req.slot;
          oor_next    = req_oor;
          rd_en       = 1'b1;
          if (req.action == ACT_GET) begin
            rd_addr         = '0;
            free_found_next = 1'b0;
            state_next      = S_SCAN;
          end else begin
            rd_addr    = req_oor ? '0 : IDX_W'(req.slot);
            state_next = S_PUT;
          end
          rd_idx_next = rd_addr;
        end
      end

      S_SCAN: begin
        if (!flags.zero && flags.match) begin
          // Hit: bump the count unless saturated
          rsp_next.slot_index = 6'(rd_idx);
          rsp_next.slot_inode = 16'(rd_num);
          if (flags.at_max) begin
            rsp_next.status      = ST_SAT;
            rsp_next.count_after = 16'(rd_cnt);
          end else begin
            cnt_we               = 1'b1;
            rsp_next.status      = ST_HIT;
            rsp_next.count_after = 16'(sum);
          end
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (rd_idx == LAST) begin
          // Scan finished without a hit: claim the first free slot
          if (free_found || flags.zero) begin
            wr_addr              = free_found ? free_idx : rd_idx;
            wr_cnt               = COUNT_BITS'(1);
            num_we               = 1'b1;
            cnt_we               = 1'b1;
            rsp_next.status      = ST_LOAD;
            rsp_next.slot_index  = 6'(wr_addr);
            rsp_next.slot_inode  = 16'(key);
            rsp_next.count_after = 16'd1;
          end else begin
            rsp_next.status      = ST_FULL;
            rsp_next.slot_index  = '0;
            rsp_next.slot_inode  = '0;
            rsp_next.count_after = '0;
          end
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          // Remember the lowest free slot and advance
          if (flags.zero && !free_found) begin
            free_idx_next   = rd_idx;
            free_found_next = 1'b1;
          end
          rd_en       = 1'b1;
          rd_addr     = rd_idx + IDX_W'(1);
          rd_idx_next = rd_addr;
        end
      end

      S_PUT: begin
        rsp_next.slot_index = slot_q;
        if (oor || flags.zero) begin
          rsp_next.status      = ST_IDLE;
          rsp_next.slot_inode  = '0;
          rsp_next.count_after = '0;
        end else begin
          cnt_we               = 1'b1;
          rsp_next.status      = flags.sum_zero ? ST_WRITEBACK : ST_HELD;
          rsp_next.slot_inode  = 16'(rd_num);
          rsp_next.count_after = 16'(sum);
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    key        <= key_next;
    slot_q     <= slot_q_next;
    oor        <= oor_next;
    rd_idx     <= rd_idx_next;
    free_idx   <= free_idx_next;
    free_found <= free_found_next;
    rsp        <= rsp_next;
  end

  // Each result follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result issued without work in progress");

  // An accepted request always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start work");

  // One strobe per request
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // A full table reports zero fields
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FULL) |-> (rsp.slot_index == '0 && rsp.count_after == '0))
    else $error("full-table result carries nonzero fields");

endmodule

`default_nettype wire

/* rtl/ist_store.sv */
// Slot storage: inode number memory and reference count memory.
// One read port with registered data, one write port; count reads as zero
// until its slot is first written. Depends on ist_pkg.
`default_nettype none

module ist_store #(
  parameter int SLOTS      = ist_pkg::SLOTS_DEF,
  parameter int INODE_BITS = ist_pkg::INODE_BITS_DEF,
  parameter int COUNT_BITS = ist_pkg::COUNT_BITS_DEF,
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_en,
  input  wire logic [IDX_W-1:0]      rd_addr,
  output logic      [INODE_BITS-1:0] rd_num,
  output logic      [COUNT_BITS-1:0] rd_cnt,
  input  wire logic                  num_we,
  input  wire logic                  cnt_we,
  input  wire logic [IDX_W-1:0]      wr_addr,
  input  wire logic [INODE_BITS-1:0] wr_num,
  input  wire logic [COUNT_BITS-1:0] wr_cnt
);
  import ist_pkg::*;

  logic [INODE_BITS-1:0] num_mem [SLOTS];
  logic [COUNT_BITS-1:0] cnt_mem [SLOTS];
  logic [SLOTS-1:0]      valid;
  logic [COUNT_BITS-1:0] cnt_raw;
  logic                  cnt_vld;

  // Write the memories
  always_ff @(posedge clk) begin
    if (num_we) begin
      num_mem[wr_addr] <= wr_num;
    end
    if (cnt_we) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
  end

  // Read the memories, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_num  <= num_mem[rd_addr];
      cnt_raw <= cnt_mem[rd_addr];
    end
  end

  // Track which counts have been written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      cnt_vld <= 1'b0;
    end else begin
      if (cnt_we) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        cnt_vld <= valid[rd_addr];
      end
    end
  end

  // Unwritten counts read as zero
  assign rd_cnt = cnt_vld ? cnt_raw : '0;

endmodule

`default_nettype wire

/* rtl/ist_unit.sv */
// Shared compare and count unit used on every scan and release step.
// One key compare and one increment/decrement adder. Depends on ist_pkg.
`default_nettype none

module ist_unit #(
  parameter int INODE_BITS = ist_pkg::INODE_BITS_DEF,
  parameter int COUNT_BITS = ist_pkg::COUNT_BITS_DEF
) (
  input  wire logic [INODE_BITS-1:0] number,
  input  wire logic [INODE_BITS-1:0] key,
  input  wire logic [COUNT_BITS-1:0] count,
  input  wire logic                  dec,
  output logic      [COUNT_BITS-1:0] sum,
  output ist_pkg::unit_flags_t       flags
);
  import ist_pkg::*;

  // Add one, or add all ones to subtract one
  assign sum = count + (dec ? {COUNT_BITS{1'b1}} : COUNT_BITS'(1));

  // Compare and classify
  assign flags.match    = (number == key);
  assign flags.zero     = (count == '0);
  assign flags.at_max   = &count;
  assign flags.sum_zero = (sum == '0);

endmodule

`default_nettype wire
